// ----- rtl/drmq_pkg.sv -----
// ----------------------------------------------------------------------------
// drmq_pkg: shared definitions for the dirty rectangle merge queue
// Slot count, index helpers, operation codes and the stored entry layout.
// ----------------------------------------------------------------------------
package drmq_pkg;

  localparam int AREA_SLOTS = 16;
  localparam int IDX_W      = $clog2(AREA_SLOTS);
  localparam int ENTRY_W    = 64;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_PEEK   = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;

  // Stored entry: x[15:0], y[31:16], w[47:32], h[63:48].
  typedef struct packed {
    logic [15:0] h;
    logic [15:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } entry_t;

  // Next ring slot, wrapping at the slot count.
  function automatic idx_t idx_inc(input idx_t a);
    idx_t r;
    if (a == idx_t'(AREA_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = a + idx_t'(1);
    end
    return r;
  endfunction

  // Number of occupied slots between read and write index.
  function automatic idx_t idx_count(input idx_t rd, input idx_t wr);
    idx_t r;
    if (wr >= rd) begin
      r = wr - rd;
    end else begin
      r = idx_t'(AREA_SLOTS - int'(rd) + int'(wr));
    end
    return r;
  endfunction

endpackage

// ----- rtl/drmq_ram.sv -----
// ----------------------------------------------------------------------------
// drmq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module drmq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/dirty_rect_merge_queue.sv -----
// ----------------------------------------------------------------------------
// dirty_rect_merge_queue: ring queue of pending redraw rectangles
// Appends merge into every overlapping queued entry, else join the tail or are dropped when full; peek, pop and clear.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and returns exactly one result
// word for it. An append walks the queued entries from head to tail through
// the rectangle memory, one entry read per cycle, with the overlap test and
// union write-back in the cycle after the read. A peek or pop on a nonempty
// queue reads only the head entry; an append on an empty queue, a clear or an
// empty peek or pop reads none. The finish state waits while the result
// register holds a word not yet taken on m_axis_tready.
// The next command is taken as soon as the block returns to idle, even while
// the previous result still waits in the output register. The rectangle
// memory needs no initialization: only entries between the read and write
// index are ever read.
module dirty_rect_merge_queue
  import drmq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Command word. tdata: rect_x[15:0], rect_y[31:16], rect_w[46:32],
  // rect_h[61:47], zero [63:62]. tuser: opcode[1:0].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  // Result word. tdata: head_x[15:0], head_y[31:16], head_w[47:32],
  // head_h[63:48], pending[67:64], merged[68], dropped[69], zero [71:70].
  // tuser: head_valid[0].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state;

  // Ring indices.
  idx_t rd_idx;
  idx_t wr_idx;

  // Latched command.
  logic [1:0]  op;
  logic [15:0] nr_x;
  logic [15:0] nr_y;
  logic [14:0] nr_w;
  logic [14:0] nr_h;

  // Scan control: reads issued in one cycle are processed in the next.
  idx_t   issue_left;
  idx_t   scan_addr;
  logic   p_valid;
  idx_t   p_addr;
  logic   p_first;
  logic   any_merge;
  entry_t head_r;

  // Memory ports.
  logic   ram_wr_en;
  idx_t   ram_wr_addr;
  entry_t ram_wr_data;
  logic   ram_rd_en;
  entry_t ram_rd_data;

  drmq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(AREA_SLOTS)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(scan_addr),
    .rd_data(ram_rd_data)
  );

  assign s_axis_tready = (state == ST_IDLE);

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  idx_t count_now;
  assign count_now = idx_count(rd_idx, wr_idx);

  // Number of entries the incoming command has to read.
  idx_t scan_len;
  always_comb begin
    case (s_axis_tuser)
      OP_APPEND: scan_len = count_now;
      OP_PEEK,
      OP_POP:    scan_len = (count_now != '0) ? idx_t'(1) : '0;
      default:   scan_len = '0;
    endcase
  end

  // Overlap test and bounding union of the fetched entry with the new one.
  entry_t              ent;
  logic signed [17:0]  e_l, e_t, e_r, e_b;
  logic signed [17:0]  n_l, n_t, n_r, n_b;
  logic signed [17:0]  u_l, u_t, u_r, u_b;
  logic signed [18:0]  span_w, span_h;
  logic                overlap;
  entry_t              joined;

  always_comb begin
    ent = ram_rd_data;
    e_l = {{2{ent.x[15]}}, ent.x};
    e_t = {{2{ent.y[15]}}, ent.y};
    e_r = e_l + $signed({2'b00, ent.w});
    e_b = e_t + $signed({2'b00, ent.h});
    n_l = {{2{nr_x[15]}}, nr_x};
    n_t = {{2{nr_y[15]}}, nr_y};
    n_r = n_l + $signed({3'b000, nr_w});
    n_b = n_t + $signed({3'b000, nr_h});
    overlap = (e_l < n_r) && (n_l < e_r) && (e_t < n_b) && (n_t < e_b);
    u_l = (e_l < n_l) ? e_l : n_l;
    u_t = (e_t < n_t) ? e_t : n_t;
    u_r = (e_r > n_r) ? e_r : n_r;
    u_b = (e_b > n_b) ? e_b : n_b;
    span_w = {u_r[17], u_r} - {u_l[17], u_l};
    span_h = {u_b[17], u_b} - {u_t[17], u_t};
    joined.x = u_l[15:0];
    joined.y = u_t[15:0];
    // Spans are never negative; anything past 16 bits saturates.
    joined.w = (span_w[18:16] != 3'b000) ? 16'hFFFF : span_w[15:0];
    joined.h = (span_h[18:16] != 3'b000) ? 16'hFFFF : span_h[15:0];
  end

  // Result of the command, evaluated in the finish state.
  logic   out_load;
  logic   do_append;
  logic   do_drop;
  idx_t   rd_new;
  idx_t   wr_new;
  idx_t   count_after;
  logic   hv;
  entry_t head_sel;
  entry_t nr_entry;

  assign nr_entry = '{h: {1'b0, nr_h}, w: {1'b0, nr_w}, y: nr_y, x: nr_x};
  assign out_load = (state == ST_FINISH) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    do_append = (op == OP_APPEND) && !any_merge &&
                (count_now < idx_t'(AREA_SLOTS - 1));
    do_drop   = (op == OP_APPEND) && !any_merge && !do_append;
    rd_new    = rd_idx;
    wr_new    = wr_idx;
    case (op)
      OP_APPEND: begin
        if (do_append) begin
          wr_new = idx_inc(wr_idx);
        end
      end
      OP_POP: begin
        if (count_now != '0) begin
          rd_new = idx_inc(rd_idx);
        end
      end
      OP_CLEAR: begin
        rd_new = '0;
        wr_new = '0;
      end
      default: begin
      end
    endcase
    count_after = idx_count(rd_new, wr_new);
    case (op)
      OP_POP:   hv = (count_now != '0);
      OP_CLEAR: hv = 1'b0;
      default:  hv = (count_after != '0);
    endcase
    // An append into an empty queue reports the new rectangle as the head.
    if (!hv) begin
      head_sel = '0;
    end else if (op == OP_APPEND && count_now == '0) begin
      head_sel = nr_entry;
    end else begin
      head_sel = head_r;
    end
  end

  // Memory write: union write-back during the scan, new tail at finish.
  always_comb begin
    ram_rd_en   = (state == ST_SCAN) && (issue_left != '0);
    ram_wr_en   = 1'b0;
    ram_wr_addr = p_addr;
    ram_wr_data = joined;
    if (state == ST_SCAN && p_valid && op == OP_APPEND && overlap) begin
      ram_wr_en = 1'b1;
    end else if (out_load && do_append) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = wr_idx;
      ram_wr_data = nr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rd_idx        <= '0;
      wr_idx        <= '0;
      p_valid       <= 1'b0;
      issue_left    <= '0;
      any_merge     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // A new result loaded in the same cycle keeps the word valid.
      if (m_axis_tvalid && m_axis_tready && !out_load) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            op         <= s_axis_tuser;
            nr_x       <= s_axis_tdata[15:0];
            nr_y       <= s_axis_tdata[31:16];
            nr_w       <= s_axis_tdata[46:32];
            nr_h       <= s_axis_tdata[61:47];
            issue_left <= scan_len;
            scan_addr  <= rd_idx;
            any_merge  <= 1'b0;
            p_valid    <= 1'b0;
            state      <= (scan_len != '0) ? ST_SCAN : ST_FINISH;
          end
        end
        ST_SCAN: begin
          p_valid <= ram_rd_en;
          p_addr  <= scan_addr;
          p_first <= (scan_addr == rd_idx);
          if (ram_rd_en) begin
            scan_addr  <= idx_inc(scan_addr);
            issue_left <= issue_left - idx_t'(1);
          end
          if (p_valid) begin
            if (op == OP_APPEND) begin
              if (overlap) begin
                any_merge <= 1'b1;
              end
              if (p_first) begin
                head_r <= overlap ? joined : ent;
              end
            end else begin
              head_r <= ent;
            end
          end
          if (issue_left == '0) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          p_valid <= 1'b0;
          if (out_load) begin
            rd_idx        <= rd_new;
            wr_idx        <= wr_new;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register holds the payload; it is loaded only from the finish state.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tuser <= hv;
      m_axis_tdata <= {2'b00, do_drop, (op == OP_APPEND) && any_merge,
                       4'(count_after), head_sel};
    end
  end

  // A result never reports both a merge and a drop.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[68] && m_axis_tdata[69]))
    else $error("merged and dropped both set");

  // An empty head report carries zero coordinates.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[63:0] == 64'd0))
    else $error("head fields nonzero without head_valid");

  // Every read of the scan has been issued by the time the block is in the finish state.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> (issue_left == '0))
    else $error("scan ended with reads outstanding");

  // An accepted command always leaves the idle state.
  assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state != ST_IDLE))
    else $error("command accepted but block stayed idle");

endmodule
